// ===== hw/rtl/baro_sensor_compensation_macros.svh =====
// Assertion macros used by the compensation block's controller.
`ifndef BARO_SENSOR_COMPENSATION_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
`define BSC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define BSC_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);
`else
`define BSC_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define BSC_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif
`endif

// ===== hw/rtl/bsc_pkg.sv =====
// Types, constants and helper functions of the pressure and temperature compensation.
package bsc_pkg;

	localparam int unsigned RawW  = 20;
	localparam int unsigned CoefW = 48;
	localparam int unsigned WordW = 64;
	localparam int unsigned TempW = 32;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_TEMP    = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PRESS_A = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PRESS_B = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_PRESS_C = 2'd3;

	localparam logic [WordW-1:0] FineOffset = 64'd128000;
	localparam logic [WordW-1:0] RawFull    = 64'd1048576;
	localparam logic [WordW-1:0] PressScale = 64'd3125;
	localparam logic [WordW-1:0] DenBias    = 64'd1 << 47;
	localparam logic [TempW-1:0] TempRound  = 32'd128;
	localparam logic [WordW-1:0] TempMul    = 64'd5;

	typedef enum logic [3:0] {
		ST_T0, ST_T1, ST_T2, ST_T3,
		ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
		ST_P5, ST_P6, ST_P7, ST_P8, ST_P9
	} step_t;

	typedef enum logic [2:0] {
		S_IDLE, S_START, S_STEP, S_WAIT, S_CHK, S_DIV_GO, S_DIV_WAIT, S_OUT
	} state_t;

	typedef struct packed {
		logic  load;
		logic  mul_start;
		logic  div_start;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic den_zero;
		logic want_t;
		logic want_p;
	} status_t;

	// Arithmetic right shifts on raw bit vectors.
	function automatic logic [TempW-1:0] asr32(logic [TempW-1:0] x, int unsigned n);
		return TempW'($signed(x) >>> n);
	endfunction

	function automatic logic [WordW-1:0] asr64(logic [WordW-1:0] x, int unsigned n);
		return WordW'($signed(x) >>> n);
	endfunction

	// One 16-bit calibration field, sign-extended or zero-extended to a full word.
	function automatic logic [WordW-1:0] coef(logic [CoefW-1:0] r, int unsigned k, logic sgn);
		logic [15:0] v;
		v = r[16*k +: 16];
		return sgn ? WordW'($signed(v)) : WordW'(v);
	endfunction

endpackage

// ===== hw/rtl/bsc_in_if.sv =====
// Input channel carrying raw readings and request flags.
interface bsc_in_if;
	logic                           valid;
	logic                           ready;
	logic [bsc_pkg::RawW-1:0]       raw_temperature;
	logic [bsc_pkg::RawW-1:0]       raw_pressure;
	logic                           want_temperature;
	logic                           want_pressure;

	modport source (output valid, raw_temperature, raw_pressure, want_temperature,
		want_pressure, input ready);
	modport sink (input valid, raw_temperature, raw_pressure, want_temperature,
		want_pressure, output ready);
endinterface

// ===== hw/rtl/bsc_out_if.sv =====
// Output channel carrying compensated temperature and pressure.
interface bsc_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [bsc_pkg::TempW-1:0] temperature_centi;
	logic [bsc_pkg::TempW-1:0]       pressure_q24_8;
	logic                            temperature_valid;
	logic                            pressure_valid;

	modport source (output valid, temperature_centi, pressure_q24_8, temperature_valid,
		pressure_valid, input ready);
	modport sink (input valid, temperature_centi, pressure_q24_8, temperature_valid,
		pressure_valid, output ready);
endinterface

// ===== hw/rtl/baro_sensor_compensation.sv =====
// Each accepted input beat runs up to 14 multiply steps and at most one radix-2 division; a zero
// divisor skips the remaining steps. Short multipliers finish their steps sooner.
// One item is in flight at a time; the result beat waits for ready, and the next input beat is
// taken the cycle after the result beat.
// Reset: arst_n clears the controller, the calibration registers and fine temperature to zero.
module baro_sensor_compensation (
	input  logic                           clk,
	input  logic                           arst_n,
	bsc_in_if.sink                         in_ch,
	bsc_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [bsc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [bsc_pkg::CoefW-1:0]      cfg_data
);
	bsc_pkg::cmd_t    cmd;
	bsc_pkg::status_t st;
	logic [bsc_pkg::TempW-1:0] temp_raw;

	bsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	bsc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.raw_temperature   (in_ch.raw_temperature),
		.raw_pressure      (in_ch.raw_pressure),
		.want_temperature  (in_ch.want_temperature),
		.want_pressure     (in_ch.want_pressure),
		.cmd               (cmd),
		.st                (st),
		.temperature_centi (temp_raw),
		.pressure_q24_8    (out_ch.pressure_q24_8),
		.temperature_valid (out_ch.temperature_valid),
		.pressure_valid    (out_ch.pressure_valid)
	);

	assign out_ch.temperature_centi = $signed(temp_raw);
endmodule

// ===== hw/rtl/bsc_mul.sv =====
// Iterative shift-and-add multiplier giving the low 64 bits of a product.
module bsc_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bsc_pkg::WordW-1:0]    a,
	input  logic [bsc_pkg::WordW-1:0]    b,
	output logic                         done,
	output logic [bsc_pkg::WordW-1:0]    prod
);
	logic                      busy_q;
	logic [bsc_pkg::WordW-1:0] a_q;
	logic [bsc_pkg::WordW-1:0] b_q;
	logic [bsc_pkg::WordW-1:0] p_q;

	// Finished once no multiplier bits remain.
	assign done = busy_q && (b_q == '0);
	assign prod = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// One multiplier bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && !done) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end
endmodule

// ===== hw/rtl/bsc_div.sv =====
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
module bsc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bsc_pkg::WordW-1:0]    num,
	input  logic [bsc_pkg::WordW-1:0]    den,
	output logic                         done,
	output logic [bsc_pkg::WordW-1:0]    quo
);
	localparam int unsigned CntW = $clog2(bsc_pkg::WordW + 1);

	logic                      busy_q;
	logic [CntW-1:0]           cnt_q;
	logic                      neg_q;
	logic [bsc_pkg::WordW-1:0] ad_q;
	logic [bsc_pkg::WordW-1:0] rem_q;
	logic [bsc_pkg::WordW-1:0] q_q;
	logic [bsc_pkg::WordW:0]   rem_sh;
	logic                      fits;

	assign rem_sh = {rem_q, q_q[bsc_pkg::WordW-1]};
	assign fits   = rem_sh >= {1'b0, ad_q};
	assign done   = busy_q && (cnt_q == CntW'(bsc_pkg::WordW));
	assign quo    = neg_q ? (~q_q + 1'b1) : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Magnitudes at start, then one restoring step per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[bsc_pkg::WordW-1] ^ den[bsc_pkg::WordW-1];
			ad_q  <= den[bsc_pkg::WordW-1] ? (~den + 1'b1) : den;
			q_q   <= num[bsc_pkg::WordW-1] ? (~num + 1'b1) : num;
			rem_q <= '0;
		end else if (busy_q && !done) begin
			rem_q <= fits ? bsc_pkg::WordW'(rem_sh - {1'b0, ad_q})
				: rem_sh[bsc_pkg::WordW-1:0];
			q_q   <= {q_q[bsc_pkg::WordW-2:0], fits};
		end
	end
endmodule

// ===== hw/rtl/bsc_dp.sv =====
// Datapath: calibration registers, working registers, multiplier, divider and results.
module bsc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bsc_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [bsc_pkg::CoefW-1:0]         cfg_data,
	input  logic [bsc_pkg::RawW-1:0]          raw_temperature,
	input  logic [bsc_pkg::RawW-1:0]          raw_pressure,
	input  logic                              want_temperature,
	input  logic                              want_pressure,
	input  bsc_pkg::cmd_t                     cmd,
	output bsc_pkg::status_t                  st,
	output logic [bsc_pkg::TempW-1:0]         temperature_centi,
	output logic [bsc_pkg::TempW-1:0]         pressure_q24_8,
	output logic                              temperature_valid,
	output logic                              pressure_valid
);
	localparam int unsigned W = bsc_pkg::WordW;
	localparam int unsigned T = bsc_pkg::TempW;

	logic [bsc_pkg::CoefW-1:0] tc_q, pa_q, pb_q, pc_q;
	logic [T-1:0]              ft_q;
	logic [bsc_pkg::RawW-1:0]  rt_q, rp_q;
	logic [W-1:0]              ra_q, rb_q, rc_q, rd_q;
	logic [T-1:0]              tout_q, pout_q;
	logic                      tv_q, pv_q;

	logic [W-1:0] mul_a, mul_b, prod, quo, pv1, hval, num;
	logic [T-1:0] t1, ta, td, p32;
	logic         mul_done, div_done;

	// Calibration registers and the stored fine temperature.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
			pa_q <= '0;
			pb_q <= '0;
			pc_q <= '0;
			ft_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bsc_pkg::REG_TEMP:    tc_q <= cfg_data;
					bsc_pkg::REG_PRESS_A: pa_q <= cfg_data;
					bsc_pkg::REG_PRESS_B: pb_q <= cfg_data;
					bsc_pkg::REG_PRESS_C: pc_q <= cfg_data;
					default: ;
				endcase
			end
			if (mul_done && cmd.step == bsc_pkg::ST_T2) begin
				ft_q <= ra_q[T-1:0] + bsc_pkg::asr32(prod[T-1:0], 14);
			end
		end
	end

	// Operand preparation.
	assign t1   = T'(bsc_pkg::coef(tc_q, 0, 1'b0));
	assign ta   = T'(rt_q >> 3) - (t1 << 1);
	assign td   = T'(rt_q >> 4) - t1;
	assign pv1  = W'($signed(ft_q)) - bsc_pkg::FineOffset;
	assign hval = bsc_pkg::asr64(rd_q, 13);
	assign num  = ((bsc_pkg::RawFull - W'(rp_q)) << 31) - rb_q;

	// Multiplier operands for each step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.step)
			bsc_pkg::ST_T0: begin mul_a = W'(ta); mul_b = bsc_pkg::coef(tc_q, 1, 1'b1); end
			bsc_pkg::ST_T1: begin mul_a = W'(td); mul_b = W'(td); end
			bsc_pkg::ST_T2: begin mul_a = rb_q; mul_b = bsc_pkg::coef(tc_q, 2, 1'b1); end
			bsc_pkg::ST_T3: begin mul_a = W'(ft_q); mul_b = bsc_pkg::TempMul; end
			bsc_pkg::ST_P0: begin mul_a = pv1; mul_b = pv1; end
			bsc_pkg::ST_P1: begin mul_a = ra_q; mul_b = bsc_pkg::coef(pb_q, 2, 1'b1); end
			bsc_pkg::ST_P2: begin mul_a = pv1; mul_b = bsc_pkg::coef(pb_q, 1, 1'b1); end
			bsc_pkg::ST_P3: begin mul_a = ra_q; mul_b = bsc_pkg::coef(pa_q, 2, 1'b1); end
			bsc_pkg::ST_P4: begin mul_a = pv1; mul_b = bsc_pkg::coef(pa_q, 1, 1'b1); end
			bsc_pkg::ST_P5: begin
				mul_a = ra_q + bsc_pkg::DenBias;
				mul_b = bsc_pkg::coef(pa_q, 0, 1'b0);
			end
			bsc_pkg::ST_P6: begin mul_a = num; mul_b = bsc_pkg::PressScale; end
			bsc_pkg::ST_P7: begin mul_a = hval; mul_b = hval; end
			bsc_pkg::ST_P8: begin mul_a = ra_q; mul_b = bsc_pkg::coef(pc_q, 2, 1'b1); end
			bsc_pkg::ST_P9: begin mul_a = rd_q; mul_b = bsc_pkg::coef(pc_q, 1, 1'b1); end
			default: ;
		endcase
	end

	bsc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	bsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (ra_q),
		.den    (rc_q),
		.done   (div_done),
		.quo    (quo)
	);

	// Final pressure: sum of the corrections, scaled, plus the offset term.
	assign p32 = T'(bsc_pkg::asr64(rd_q + ra_q + bsc_pkg::asr64(prod, 19), 8)
		+ (bsc_pkg::coef(pc_q, 0, 1'b1) << 4));

	// Input capture and step write-back.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rt_q   <= raw_temperature;
			rp_q   <= raw_pressure;
			tv_q   <= want_temperature;
			pv_q   <= want_pressure;
			tout_q <= '0;
			pout_q <= '0;
		end
		if (div_done) begin
			rd_q <= quo;
		end
		if (mul_done) begin
			unique case (cmd.step)
				bsc_pkg::ST_T0: ra_q <= W'(bsc_pkg::asr32(prod[T-1:0], 11));
				bsc_pkg::ST_T1: rb_q <= W'(bsc_pkg::asr32(prod[T-1:0], 12));
				bsc_pkg::ST_T2: ;
				bsc_pkg::ST_T3: tout_q <= bsc_pkg::asr32(prod[T-1:0] + bsc_pkg::TempRound, 8);
				bsc_pkg::ST_P0: ra_q <= prod;
				bsc_pkg::ST_P1: rb_q <= prod;
				bsc_pkg::ST_P2: rb_q <= rb_q + (prod << 17) + (bsc_pkg::coef(pb_q, 0, 1'b1) << 35);
				bsc_pkg::ST_P3: ra_q <= bsc_pkg::asr64(prod, 8);
				bsc_pkg::ST_P4: ra_q <= ra_q + (prod << 12);
				bsc_pkg::ST_P5: rc_q <= bsc_pkg::asr64(prod, 33);
				bsc_pkg::ST_P6: ra_q <= prod;
				bsc_pkg::ST_P7: ra_q <= prod;
				bsc_pkg::ST_P8: ra_q <= bsc_pkg::asr64(prod, 25);
				bsc_pkg::ST_P9: pout_q <= p32;
				default: ;
			endcase
		end
	end

	assign st.mul_done = mul_done;
	assign st.div_done = div_done;
	assign st.den_zero = (rc_q == '0);
	assign st.want_t   = tv_q;
	assign st.want_p   = pv_q;

	assign temperature_centi = tout_q;
	assign pressure_q24_8    = pout_q;
	assign temperature_valid = tv_q;
	assign pressure_valid    = pv_q;
endmodule

// ===== hw/rtl/bsc_ctrl.sv =====
// Controller: sequences the compensation steps and runs the handshakes.
`include "baro_sensor_compensation_macros.svh"
module bsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bsc_pkg::status_t  st,
	output bsc_pkg::cmd_t     cmd
);
	bsc_pkg::state_t state_q, state_d;
	bsc_pkg::step_t  step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsc_pkg::S_IDLE;
			step_q  <= bsc_pkg::ST_T0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		step_d        = step_q;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd.load      = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.div_start = 1'b0;
		cmd.step      = step_q;
		unique case (state_q)
			bsc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bsc_pkg::S_START;
				end
			end
			bsc_pkg::S_START: begin
				if (st.want_t) begin
					step_d  = bsc_pkg::ST_T0;
					state_d = bsc_pkg::S_STEP;
				end else if (st.want_p) begin
					step_d  = bsc_pkg::ST_P0;
					state_d = bsc_pkg::S_STEP;
				end else begin
					state_d = bsc_pkg::S_OUT;
				end
			end
			bsc_pkg::S_STEP: begin
				cmd.mul_start = 1'b1;
				state_d       = bsc_pkg::S_WAIT;
			end
			bsc_pkg::S_WAIT: begin
				if (st.mul_done) begin
					state_d = bsc_pkg::S_STEP;
					unique case (step_q)
						bsc_pkg::ST_T0: step_d = bsc_pkg::ST_T1;
						bsc_pkg::ST_T1: step_d = bsc_pkg::ST_T2;
						bsc_pkg::ST_T2: step_d = bsc_pkg::ST_T3;
						bsc_pkg::ST_T3: begin
							if (st.want_p) begin
								step_d = bsc_pkg::ST_P0;
							end else begin
								state_d = bsc_pkg::S_OUT;
							end
						end
						bsc_pkg::ST_P0: step_d = bsc_pkg::ST_P1;
						bsc_pkg::ST_P1: step_d = bsc_pkg::ST_P2;
						bsc_pkg::ST_P2: step_d = bsc_pkg::ST_P3;
						bsc_pkg::ST_P3: step_d = bsc_pkg::ST_P4;
						bsc_pkg::ST_P4: step_d = bsc_pkg::ST_P5;
						bsc_pkg::ST_P5: state_d = bsc_pkg::S_CHK;
						bsc_pkg::ST_P6: state_d = bsc_pkg::S_DIV_GO;
						bsc_pkg::ST_P7: step_d = bsc_pkg::ST_P8;
						bsc_pkg::ST_P8: step_d = bsc_pkg::ST_P9;
						bsc_pkg::ST_P9: state_d = bsc_pkg::S_OUT;
						default: state_d = bsc_pkg::S_OUT;
					endcase
				end
			end
			bsc_pkg::S_CHK: begin
				// A zero divisor leaves the pressure at zero.
				if (st.den_zero) begin
					state_d = bsc_pkg::S_OUT;
				end else begin
					step_d  = bsc_pkg::ST_P6;
					state_d = bsc_pkg::S_STEP;
				end
			end
			bsc_pkg::S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = bsc_pkg::S_DIV_WAIT;
			end
			bsc_pkg::S_DIV_WAIT: begin
				if (st.div_done) begin
					step_d  = bsc_pkg::ST_P7;
					state_d = bsc_pkg::S_STEP;
				end
			end
			bsc_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = bsc_pkg::S_IDLE;
				end
			end
			default: state_d = bsc_pkg::S_IDLE;
		endcase
	end

	`BSC_ASSERT(a_accept_leaves_idle, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "accepted beat did not start work")
	`BSC_ASSERT(a_out_returns_idle, clk, arst_n, (out_valid && out_ready) |=> in_ready, "delivered beat did not return to idle")
	`BSC_ASSERT_NEVER(a_ready_and_valid, clk, arst_n, in_ready && out_valid, "input taken while a result waits")
	`BSC_ASSERT_NEVER(a_mul_in_idle, clk, arst_n, in_ready && st.mul_done, "multiplier finished with no step running")
endmodule

// ===== tb/sv/baro_sensor_compensation_test.sv =====
// Self-checking testbench of the barometric temperature and pressure compensation block.
module baro_sensor_compensation_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IdleLimit = 60000;
	localparam int unsigned RandItems = 330;
	localparam int unsigned DirRows = 20;

	typedef struct {
		bit [bsc_pkg::RawW-1:0] raw_t;
		bit [bsc_pkg::RawW-1:0] raw_p;
		bit                     want_t;
		bit                     want_p;
	} reading_t;

	typedef struct {
		bit [bsc_pkg::TempW-1:0] temp;
		bit [bsc_pkg::TempW-1:0] press;
		bit                      temp_ok;
		bit                      press_ok;
	} comp_result_t;

	// One directed row: the calibration set it runs under and, where fixed, its outcome.
	typedef struct {
		bit                      cal_typical;
		bit [bsc_pkg::RawW-1:0]  raw_t;
		bit [bsc_pkg::RawW-1:0]  raw_p;
		bit                      want_t;
		bit                      want_p;
		bit                      fixed;
		bit [bsc_pkg::TempW-1:0] exp_temp;
		bit [bsc_pkg::TempW-1:0] exp_press;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bsc_pkg::CfgIdxW-1:0] cfg_index;
	logic [bsc_pkg::CoefW-1:0] cfg_data;

	bsc_in_if in_ch ();
	bsc_out_if out_ch ();

	baro_sensor_compensation u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow calibration and fine temperature of the predictor.
	bit [bsc_pkg::CoefW-1:0] cal_regs [4];
	bit [bsc_pkg::TempW-1:0] fine_temp;
	comp_result_t comp_q [$];
	int unsigned error_count;
	int unsigned idle_cycles;
	int unsigned cycle_count;

	// Under the reset calibration every temperature is zero and the divisor is zero.
	dir_row_t dir_rows [DirRows] = '{
		'{1'b0, 20'h00000, 20'h00000, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0},
		'{1'b0, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0, 1'b1, 32'd0, 32'd0},
		'{1'b0, 20'hFFFFF, 20'hFFFFF, 1'b0, 1'b1, 1'b1, 32'd0, 32'd0},
		'{1'b0, 20'h00000, 20'h00000, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0},
		'{1'b0, 20'hAAAAA, 20'h55555, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0},
		'{1'b1, 20'h7E4B0, 20'h65A20, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'h00000, 20'h00000, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'h00000, 20'hFFFFF, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'hFFFFF, 20'h00000, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'h80000, 20'h80000, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'h80000, 20'h80000, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'h12345, 20'h6789A, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0},
		'{1'b1, 20'h6B000, 20'h5A000, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'h00001, 20'hFFFFE, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'hFFFFE, 20'h00001, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'h55555, 20'hAAAAA, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'hAAAAA, 20'h55555, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'h7FFFF, 20'h7FFFF, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
		'{1'b1, 20'h3C000, 20'hC3000, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0}
	};

	// Temperature in 32-bit wrapping arithmetic; refreshes the fine temperature.
	function automatic bit [bsc_pkg::TempW-1:0] temp_compensate(bit [bsc_pkg::RawW-1:0] raw);
		bit [31:0] adc, t1, t2, t3, a, v1, d, v2, sq;
		adc = {12'b0, raw};
		t1 = {16'b0, cal_regs[bsc_pkg::REG_TEMP][15:0]};
		t2 = {{16{cal_regs[bsc_pkg::REG_TEMP][31]}}, cal_regs[bsc_pkg::REG_TEMP][31:16]};
		t3 = {{16{cal_regs[bsc_pkg::REG_TEMP][47]}}, cal_regs[bsc_pkg::REG_TEMP][47:32]};
		a = (adc >> 3) - (t1 << 1);
		v1 = a * t2;
		v1 = 32'($signed(v1) >>> 11);
		d = (adc >> 4) - t1;
		sq = d * d;
		sq = 32'($signed(sq) >>> 12);
		v2 = sq * t3;
		v2 = 32'($signed(v2) >>> 14);
		fine_temp = v1 + v2;
		a = fine_temp * 32'd5 + bsc_pkg::TempRound;
		return 32'($signed(a) >>> 8);
	endfunction

	// Pressure in 64-bit wrapping arithmetic from the stored fine temperature.
	function automatic bit [bsc_pkg::TempW-1:0] press_compensate(bit [bsc_pkg::RawW-1:0] raw);
		bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		bit [63:0] v1, v2, p, h, num, an, ad, q;
		bit [47:0] ra, rb, rc;
		ra = cal_regs[bsc_pkg::REG_PRESS_A];
		rb = cal_regs[bsc_pkg::REG_PRESS_B];
		rc = cal_regs[bsc_pkg::REG_PRESS_C];
		p1 = {48'b0, ra[15:0]};
		p2 = {{48{ra[31]}}, ra[31:16]};
		p3 = {{48{ra[47]}}, ra[47:32]};
		p4 = {{48{rb[15]}}, rb[15:0]};
		p5 = {{48{rb[31]}}, rb[31:16]};
		p6 = {{48{rb[47]}}, rb[47:32]};
		p7 = {{48{rc[15]}}, rc[15:0]};
		p8 = {{48{rc[31]}}, rc[31:16]};
		p9 = {{48{rc[47]}}, rc[47:32]};
		v1 = {{32{fine_temp[31]}}, fine_temp} - bsc_pkg::FineOffset;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		h = v1 * v1 * p3;
		v1 = 64'($signed(h) >>> 8) + ((v1 * p2) << 12);
		h = (bsc_pkg::DenBias + v1) * p1;
		v1 = 64'($signed(h) >>> 33);
		if (v1 == 64'd0)
			return '0;
		p = bsc_pkg::RawFull - {44'b0, raw};
		num = ((p << 31) - v2) * bsc_pkg::PressScale;
		// Signed division truncating toward zero, done on magnitudes.
		an = num[63] ? -num : num;
		ad = v1[63] ? -v1 : v1;
		q = an / ad;
		p = (num[63] != v1[63]) ? -q : q;
		h = 64'($signed(p) >>> 13);
		v1 = p9 * h * h;
		v1 = 64'($signed(v1) >>> 25);
		v2 = p8 * p;
		v2 = 64'($signed(v2) >>> 19);
		q = p + v1 + v2;
		p = 64'($signed(q) >>> 8) + (p7 << 4);
		return p[31:0];
	endfunction

	function automatic comp_result_t compensate(reading_t r);
		comp_result_t res;
		res = '{default: 0};
		if (r.want_t) begin
			res.temp = temp_compensate(r.raw_t);
			res.temp_ok = 1'b1;
		end
		if (r.want_p) begin
			res.press = press_compensate(r.raw_p);
			res.press_ok = 1'b1;
		end
		return res;
	endfunction

	task automatic report_mismatch(string field, bit [31:0] got, bit [31:0] want);
		$display("MISMATCH %s: got %h expected %h at cycle %0d", field, got, want, cycle_count);
		error_count++;
	endtask

	// Clock and reset.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver stalls: randomly while bit 12 of the cycle count is set, never while it is clear.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (cycle_count[12]) begin
			out_ch.ready <= ($urandom_range(0, 3) != 0);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Result checker and idle watchdog.
	always @(posedge clk) begin
		comp_result_t want;
		cycle_count <= cycle_count + 1;
		if (out_ch.valid && out_ch.ready && arst_n) begin
			if (comp_q.size() == 0) begin
				$display("UNEXPECTED result beat at cycle %0d", cycle_count);
				error_count++;
			end else begin
				want = comp_q.pop_front();
				if (out_ch.temperature_centi !== want.temp)
					report_mismatch("temperature_centi", out_ch.temperature_centi, want.temp);
				if (out_ch.pressure_q24_8 !== want.press)
					report_mismatch("pressure_q24_8", out_ch.pressure_q24_8, want.press);
				if (out_ch.temperature_valid !== want.temp_ok)
					report_mismatch("temperature_valid", out_ch.temperature_valid, want.temp_ok);
				if (out_ch.pressure_valid !== want.press_ok)
					report_mismatch("pressure_valid", out_ch.pressure_valid, want.press_ok);
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Write one calibration register; only called when no reading is in flight.
	task automatic write_cal(logic [bsc_pkg::CfgIdxW-1:0] idx, bit [bsc_pkg::CoefW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		cal_regs[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (comp_q.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_cal(bit [bsc_pkg::CoefW-1:0] t, bit [bsc_pkg::CoefW-1:0] a,
			bit [bsc_pkg::CoefW-1:0] b, bit [bsc_pkg::CoefW-1:0] c);
		drain();
		write_cal(bsc_pkg::REG_TEMP, t);
		write_cal(bsc_pkg::REG_PRESS_A, a);
		write_cal(bsc_pkg::REG_PRESS_B, b);
		write_cal(bsc_pkg::REG_PRESS_C, c);
	endtask

	// Present one reading and hold it until the beat is taken.
	task automatic send_reading(reading_t r, bit fixed, comp_result_t fixed_res);
		comp_result_t res;
		in_ch.valid <= 1'b1;
		in_ch.raw_temperature <= r.raw_t;
		in_ch.raw_pressure <= r.raw_p;
		in_ch.want_temperature <= r.want_t;
		in_ch.want_pressure <= r.want_p;
		do @(posedge clk); while (!in_ch.ready);
		res = compensate(r);
		comp_q.push_back(fixed ? fixed_res : res);
	endtask

	task automatic pause_sender(int unsigned gap);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic bit [bsc_pkg::RawW-1:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return bsc_pkg::RawW'($urandom);
		endcase
	endfunction

	// Random readings in bursts with random gaps.
	task automatic random_phase(int unsigned count);
		reading_t r;
		comp_result_t none;
		int unsigned burst;
		none = '{default: 0};
		burst = $urandom_range(1, 8);
		for (int unsigned i = 0; i < count; i++) begin
			r.raw_t = pick_raw();
			r.raw_p = pick_raw();
			r.want_t = $urandom_range(0, 1);
			r.want_p = $urandom_range(0, 1);
			send_reading(r, 1'b0, none);
			// Hold the sender once mid-phase until every result is back.
			if (i == count / 2) begin
				in_ch.valid <= 1'b0;
				drain();
			end else if (--burst == 0) begin
				burst = $urandom_range(1, 8);
				pause_sender($urandom_range(0, 40));
			end
		end
		pause_sender(1);
	endtask

	function automatic bit [bsc_pkg::CoefW-1:0] rand_cal();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Calibration of a typical sensor.
	localparam bit [bsc_pkg::CoefW-1:0] TypT = {16'hFC18, 16'd26435, 16'd27504};
	localparam bit [bsc_pkg::CoefW-1:0] TypA = {16'd3024, 16'hD643, 16'd36477};
	localparam bit [bsc_pkg::CoefW-1:0] TypB = {16'hFFF9, 16'd140, 16'd2855};
	localparam bit [bsc_pkg::CoefW-1:0] TypC = {16'd6000, 16'hC6F8, 16'd15500};

	initial begin
		comp_result_t fixed_res;
		reading_t r;
		bit cur_typical;
		error_count = 0;
		idle_cycles = 0;
		cycle_count = 0;
		fine_temp = '0;
		cur_typical = 1'b0;
		for (int i = 0; i < 4; i++)
			cal_regs[i] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.raw_temperature = '0;
		in_ch.raw_pressure = '0;
		in_ch.want_temperature = 1'b0;
		in_ch.want_pressure = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table.
		foreach (dir_rows[k]) begin
			if (dir_rows[k].cal_typical && !cur_typical) begin
				pause_sender(1);
				load_cal(TypT, TypA, TypB, TypC);
				cur_typical = 1'b1;
			end
			r = '{dir_rows[k].raw_t, dir_rows[k].raw_p, dir_rows[k].want_t,
				dir_rows[k].want_p};
			fixed_res = '{dir_rows[k].exp_temp, dir_rows[k].exp_press,
				dir_rows[k].want_t, dir_rows[k].want_p};
			send_reading(r, dir_rows[k].fixed, fixed_res);
			pause_sender(k % 3);
		end
		pause_sender(1);

		// Random readings under several calibrations, extremes among them.
		random_phase(RandItems);
		load_cal('1, '1, '1, '1);
		random_phase(RandItems);
		load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h0001},
			{16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000});
		random_phase(RandItems / 2);
		load_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal());
		random_phase(RandItems / 2);
		load_cal(TypT ^ 48'h0000_00FF_0F0F, TypA ^ 48'h00F0_0F00_1234, TypB, TypC);
		random_phase(RandItems);

		drain();
		repeat (1100) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_in_if.sv
hw/rtl/bsc_out_if.sv
hw/rtl/bsc_mul.sv
hw/rtl/bsc_div.sv
hw/rtl/bsc_dp.sv
hw/rtl/bsc_ctrl.sv
hw/rtl/baro_sensor_compensation.sv
tb/sv/baro_sensor_compensation_test.sv
